FILE: hdl/rlc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlc_pkg
// Shared types and constants of the escape byte run-length codec.
// ----------------------------------------------------------------------------
package rlc_pkg;

    localparam logic [7:0] ESC_BYTE        = 8'hCB;
    localparam int         MAX_RUN_DEFAULT = 250;
    localparam int         QUEUE_DEPTH     = 2;

    // Configuration register indexes.
    localparam logic CFG_MODE         = 1'b0;
    localparam logic CFG_BLOCK_LENGTH = 1'b1;

    // Values of the mode register.
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef enum logic [1:0] {
        PH_PLAIN  = 2'd0,
        PH_VALUE  = 2'd1,
        PH_LENGTH = 2'd2
    } phase_t;

    // One command from the front to the back. An encode command carries up to
    // two runs to be written out; a decode command carries one finished result.
    typedef struct packed {
        logic       dec;
        logic       run0_v;
        logic [7:0] val0;
        logic [7:0] cnt0;
        logic       run1_v;
        logic [7:0] val1;
        logic [7:0] cnt1;
        logic       done;
        logic       err;
    } cmd_t;

endpackage

FILE: hdl/rlc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlc_front
// Holds the configuration and the run and decode state, takes each input item
// and turns it into at most one command for the output side.
// ----------------------------------------------------------------------------
module rlc_front #(
    parameter int MAX_RUN = rlc_pkg::MAX_RUN_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic          cfg_addr,
    input  logic [15:0]   cfg_wdata,
    input  logic          take,
    input  logic [7:0]    data_byte,
    input  logic          end_of_block,
    output logic          cmd_valid,
    output rlc_pkg::cmd_t cmd
);
    import rlc_pkg::*;

    logic        mode_reg;
    logic [15:0] block_length_reg;

    logic [7:0]  run_value_reg, run_value_next;
    logic [7:0]  run_count_reg, run_count_next;
    logic        run_open_reg, run_open_next;

    phase_t      phase_reg, phase_next;
    logic [7:0]  esc_value_reg, esc_value_next;
    logic [15:0] produced_reg, produced_next;
    logic        halted_reg, halted_next;

    logic        extend;
    logic [7:0]  new_value;
    logic [7:0]  new_count;

    logic        dec_produce;
    logic [7:0]  dec_value;
    logic [7:0]  dec_count;
    logic [16:0] total;
    logic        overflow;
    logic        at_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_ENCODE;
            block_length_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_MODE:         mode_reg         <= cfg_wdata[0];
                CFG_BLOCK_LENGTH: block_length_reg <= cfg_wdata;
                default:          mode_reg         <= mode_reg;
            endcase
        end
    end

    // Encode: a byte extends the open run unless it differs or the run is full.
    assign extend    = run_open_reg && (data_byte == run_value_reg)
                       && (run_count_reg < 8'(MAX_RUN));
    assign new_value = extend ? run_value_reg : data_byte;
    assign new_count = extend ? run_count_reg + 8'd1 : 8'd1;

    always_comb
    begin
        run_value_next = run_value_reg;
        run_count_next = run_count_reg;
        run_open_next  = run_open_reg;
        if (take && mode_reg == MODE_ENCODE)
        begin
            run_value_next = new_value;
            run_count_next = end_of_block ? 8'd0 : new_count;
            run_open_next  = !end_of_block;
        end
    end

    // Decode: which result, if any, this byte produces.
    always_comb
    begin
        dec_produce = 1'b0;
        dec_value   = data_byte;
        dec_count   = 8'd1;
        if (!halted_reg)
        begin
            unique case (phase_reg)
                PH_VALUE:
                begin
                    dec_produce = 1'b0;
                end
                PH_LENGTH:
                begin
                    dec_produce = (data_byte != 8'd0);
                    dec_value   = esc_value_reg;
                    dec_count   = data_byte;
                end
                default:
                begin
                    dec_produce = (data_byte != ESC_BYTE);
                end
            endcase
        end
    end

    assign total    = {1'b0, produced_reg} + {9'd0, dec_count};
    assign overflow = total > {1'b0, block_length_reg};
    assign at_end   = total == {1'b0, block_length_reg};

    always_comb
    begin
        phase_next     = phase_reg;
        esc_value_next = esc_value_reg;
        produced_next  = produced_reg;
        halted_next    = halted_reg;
        if (take && mode_reg == MODE_DECODE && !halted_reg)
        begin
            unique case (phase_reg)
                PH_VALUE:
                begin
                    esc_value_next = data_byte;
                    phase_next     = PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    phase_next = PH_PLAIN;
                end
                default:
                begin
                    phase_next = (data_byte == ESC_BYTE) ? PH_VALUE : PH_PLAIN;
                end
            endcase
            if (dec_produce)
            begin
                if (overflow)
                begin
                    halted_next   = 1'b1;
                    produced_next = '0;
                end
                else
                begin
                    produced_next = at_end ? 16'd0 : total[15:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_value_reg <= '0;
            run_count_reg <= '0;
            run_open_reg  <= 1'b0;
            phase_reg     <= PH_PLAIN;
            esc_value_reg <= '0;
            produced_reg  <= '0;
            halted_reg    <= 1'b0;
        end
        else
        begin
            run_value_reg <= run_value_next;
            run_count_reg <= run_count_next;
            run_open_reg  <= run_open_next;
            phase_reg     <= phase_next;
            esc_value_reg <= esc_value_next;
            produced_reg  <= produced_next;
            halted_reg    <= halted_next;
        end
    end

    // Command built from the accepted item.
    always_comb
    begin
        cmd       = '0;
        cmd_valid = 1'b0;
        if (mode_reg == MODE_ENCODE)
        begin
            cmd.dec    = 1'b0;
            cmd.run0_v = run_open_reg && !extend;
            cmd.val0   = run_value_reg;
            cmd.cnt0   = run_count_reg;
            cmd.run1_v = end_of_block;
            cmd.val1   = new_value;
            cmd.cnt1   = new_count;
            cmd.done   = end_of_block;
            cmd_valid  = take && (cmd.run0_v || end_of_block);
        end
        else
        begin
            cmd.dec    = 1'b1;
            cmd.val0   = overflow ? 8'd0 : dec_value;
            cmd.cnt0   = overflow ? 8'd0 : dec_count;
            cmd.done   = overflow || at_end;
            cmd.err    = overflow;
            cmd_valid  = take && dec_produce;
        end
    end

endmodule

FILE: hdl/rlc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlc_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module rlc_fifo #(
    parameter int DEPTH = rlc_pkg::QUEUE_DEPTH,
    parameter int WIDTH = $bits(rlc_pkg::cmd_t)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = count_reg == CW'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hdl/rlc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlc_back
// Expands the command at the queue head into result items, one per cycle while
// the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module rlc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  rlc_pkg::cmd_t head,
    input  logic          head_valid,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic [7:0]    repeat_res,
    output logic          block_done,
    output logic          error
);
    import rlc_pkg::*;

    logic       sel_reg, sel_next;
    logic [1:0] pos_reg, pos_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic [7:0] rep_reg;
    logic       done_reg;
    logic       err_reg;

    logic       load;
    logic       issue;
    logic       second;
    logic [7:0] cur_val;
    logic [7:0] cur_cnt;
    logic       esc_form;
    logic [1:0] run_len;
    logic       run_last;
    logic       cmd_last;
    logic [7:0] enc_byte;

    assign load  = !valid_reg || out_ready;
    assign issue = load && head_valid;

    // An encode command with no closed run starts directly at the second run.
    assign second  = sel_reg || !head.run0_v;
    assign cur_val = second ? head.val1 : head.val0;
    assign cur_cnt = second ? head.cnt1 : head.cnt0;

    // Runs of three or more, and any run of the escape byte, go out as a triple.
    assign esc_form = (cur_cnt >= 8'd3) || (cur_val == ESC_BYTE);
    assign run_len  = esc_form ? 2'd3 : cur_cnt[1:0];
    assign run_last = pos_reg == run_len - 2'd1;
    assign cmd_last = head.dec || (run_last && (second || !head.run1_v));

    always_comb
    begin
        enc_byte = cur_val;
        if (esc_form)
        begin
            unique case (pos_reg)
                2'd0:    enc_byte = ESC_BYTE;
                2'd1:    enc_byte = cur_val;
                default: enc_byte = cur_cnt;
            endcase
        end
    end

    always_comb
    begin
        sel_next   = sel_reg;
        pos_next   = pos_reg;
        pop        = 1'b0;
        valid_next = valid_reg && !out_ready;
        if (issue)
        begin
            valid_next = 1'b1;
            if (cmd_last)
            begin
                sel_next = 1'b0;
                pos_next = 2'd0;
                pop      = 1'b1;
            end
            else if (run_last)
            begin
                sel_next = 1'b1;
                pos_next = 2'd0;
            end
            else
            begin
                pos_next = pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= 1'b0;
            pos_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg   <= sel_next;
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            byte_reg <= head.dec ? head.val0 : enc_byte;
            rep_reg  <= head.dec ? head.cnt0 : 8'd1;
            done_reg <= head.done && cmd_last;
            err_reg  <= head.dec && head.err;
        end
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign repeat_res = rep_reg;
    assign block_done = done_reg;
    assign error      = err_reg;

endmodule

FILE: hdl/escape_byte_rle_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_byte_rle_codec
// Byte run-length encoder and decoder with escape byte 0xCB.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tdata[7:0] data_byte, tlast end_of_block
//  m_axis    out        tdata[7:0] out_byte, tdata[15:8] repeat_res,
//                       tlast block_done, tuser error
//  cfg       in         index 0 mode, index 1 block_length
//
// An input item is taken every cycle while the two-entry command queue has room.
// The output expander writes one result item per cycle while m_axis is not stalled;
// an encode item releases zero to six coded bytes, a decode item at most one result.
// The first result of an item passes the command queue and the registered output stage.
// Reset clears the control state at once; there is no clearing pass.
// A stall on the output fills the queue and then drops s_axis_tready.
// ----------------------------------------------------------------------------
module escape_byte_rle_codec #(
    parameter int MAX_RUN = rlc_pkg::MAX_RUN_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [15:8] repeat_res
    output logic        m_axis_tlast,
    output logic [0:0]  m_axis_tuser    // [0] error
);
    import rlc_pkg::*;

    cmd_t       cmd;
    cmd_t       head;
    logic       cmd_valid;
    logic       take;
    logic       full;
    logic       empty;
    logic       pop;
    logic [7:0] out_byte;
    logic [7:0] repeat_res;

    assign s_axis_tready = !full;
    assign take          = s_axis_tvalid && !full;

    rlc_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .take         (take),
        .data_byte    (s_axis_tdata),
        .end_of_block (s_axis_tlast),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd)
    );

    rlc_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(cmd_t))
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_valid),
        .wr_data (cmd),
        .pop     (pop),
        .rd_data (head),
        .full    (full),
        .empty   (empty)
    );

    rlc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!empty),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (out_byte),
        .repeat_res (repeat_res),
        .block_done (m_axis_tlast),
        .error      (m_axis_tuser[0])
    );

    assign m_axis_tdata = {repeat_res, out_byte};

endmodule

FILE: hdl/rlc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlc_checker
// Port-level checks on the output channel of the codec.
// ----------------------------------------------------------------------------
module rlc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [0:0]  m_axis_tuser
);

    // A stalled item keeps its place.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output item dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("output item changed while stalled");

    // An overflow ends the block and carries no byte and no count.
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata == 16'd0)
        else $error("error item malformed");

    // The output stage is empty while reset is held.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("output valid during reset");

endmodule

bind escape_byte_rle_codec rlc_checker u_chk (.*);

FILE: test/escape_byte_rle_codec_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_byte_rle_codec_tb
// Self-checking bench for the escape byte run-length codec. The first rows of a
// table of directed items open the run and its last rows close it. Random encode
// runs and decode sequences come in between. Each item taken by the block is fed to
// a behavioral model of the codec, and every result item is compared field by
// field with the oldest predicted word.
// ----------------------------------------------------------------------------
module escape_byte_rle_codec_tb;

    import rlc_pkg::*;

    localparam int MAX_RUN       = MAX_RUN_DEFAULT;
    localparam int RANDOM_ITEMS  = 340;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 120;
    localparam int LIMIT_CYCLES  = 600000;
    localparam int PRINT_LIMIT   = 200;
    localparam int TAIL_START    = 25;
    localparam int ROW_COUNT     = 35;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [7:0] repeat_cnt;
        logic       block_done;
        logic       err;
    } rle_word_t;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } row_kind_t;

    // A typed row carries its own expected word instead of the predicted one.
    typedef struct packed {
        row_kind_t  kind;
        logic       cfg_index;
        logic [15:0] value;
        logic       last;
        logic       typed;
        rle_word_t  want;
    } stim_row_t;

    localparam rle_word_t NO_WORD = '0;

    localparam stim_row_t STIM_ROWS [ROW_COUNT] = '{
        // Encode after reset: lone extremes, a lone escape byte, a pair, a triple.
        '{ROW_ITEM, CFG_MODE, 16'h0000, 1'b1, 1'b1, '{8'h00, 8'h01, 1'b1, 1'b0}},
        '{ROW_ITEM, CFG_MODE, 16'h00FF, 1'b1, 1'b1, '{8'hFF, 8'h01, 1'b1, 1'b0}},
        '{ROW_ITEM, CFG_MODE, 16'h00CB, 1'b1, 1'b0, NO_WORD},
        '{ROW_ITEM, CFG_MODE, 16'h0041, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, CFG_MODE, 16'h0041, 1'b1, 1'b0, NO_WORD},
        '{ROW_ITEM, CFG_MODE, 16'h0007, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, CFG_MODE, 16'h0007, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, CFG_MODE, 16'h0007, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, CFG_MODE, 16'h0080, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, CFG_MODE, 16'h0080, 1'b1, 1'b0, NO_WORD},
        // Decode a five byte block: literal, triple, empty triple, literal.
        '{ROW_CFG,  CFG_BLOCK_LENGTH, 16'd5, 1'b0, 1'b0, NO_WORD},
        '{ROW_CFG,  CFG_MODE, {15'd0, MODE_DECODE}, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, CFG_MODE, 16'h0000, 1'b0, 1'b1, '{8'h00, 8'h01, 1'b0, 1'b0}},
        '{ROW_ITEM, CFG_MODE, 16'h00CB, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, CFG_MODE, 16'h0041, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, CFG_MODE, 16'h0003, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, CFG_MODE, 16'h00CB, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, CFG_MODE, 16'h0010, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, CFG_MODE, 16'h0000, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, CFG_MODE, 16'h00FF, 1'b1, 1'b1, '{8'hFF, 8'h01, 1'b1, 1'b0}},
        // Widest block, escape byte as the value, longest run.
        '{ROW_CFG,  CFG_BLOCK_LENGTH, 16'hFFFF, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, CFG_MODE, 16'h00CB, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, CFG_MODE, 16'h00CB, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, CFG_MODE, 16'h00FF, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, CFG_MODE, 16'h0080, 1'b1, 1'b0, NO_WORD},
        // Closing rows: a zero block length below the bytes already produced
        // overflows, decode then stays halted, encode keeps working.
        '{ROW_CFG,  CFG_MODE, {15'd0, MODE_DECODE}, 1'b0, 1'b0, NO_WORD},
        '{ROW_CFG,  CFG_BLOCK_LENGTH, 16'hFFFF, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, CFG_MODE, 16'h005A, 1'b0, 1'b0, NO_WORD},
        '{ROW_CFG,  CFG_BLOCK_LENGTH, 16'd0, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, CFG_MODE, 16'h0001, 1'b0, 1'b1, '{8'h00, 8'h00, 1'b1, 1'b1}},
        '{ROW_ITEM, CFG_MODE, 16'h00CB, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, CFG_MODE, 16'h0002, 1'b0, 1'b0, NO_WORD},
        '{ROW_CFG,  CFG_MODE, {15'd0, MODE_ENCODE}, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, CFG_MODE, 16'h0033, 1'b1, 1'b0, NO_WORD},
        '{ROW_ITEM, CFG_MODE, 16'h0033, 1'b1, 1'b1, '{8'h33, 8'h01, 1'b1, 1'b0}}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_addr;
    logic [15:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;

    // Model state of the codec.
    logic        cur_mode;
    logic [15:0] cur_block_len;
    logic [7:0]  enc_value;
    logic [7:0]  enc_count;
    logic        enc_open;
    phase_t      dec_phase;
    logic [7:0]  dec_value;
    logic [15:0] dec_produced;
    logic        dec_halted;

    rle_word_t   step_words[$];
    rle_word_t   expected_words[$];

    int fail_count    = 0;
    int items_taken   = 0;
    int cycle_count   = 0;
    int send_idle_pct = 9;
    int recv_idle_pct = 86;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    escape_byte_rle_codec #(
        .MAX_RUN(MAX_RUN)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    function automatic void emit_word(input logic [7:0] b, input logic [7:0] rep,
                                      input logic done, input logic err);
        rle_word_t w;
        w = '{b, rep, done, err};
        step_words.push_back(w);
    endfunction

    function automatic void flush_run();
        if (enc_count >= 8'd3 || enc_value == ESC_BYTE)
        begin
            emit_word(ESC_BYTE, 8'd1, 1'b0, 1'b0);
            emit_word(enc_value, 8'd1, 1'b0, 1'b0);
            emit_word(enc_count, 8'd1, 1'b0, 1'b0);
        end
        else
        begin
            emit_word(enc_value, 8'd1, 1'b0, 1'b0);
            if (enc_count == 8'd2)
                emit_word(enc_value, 8'd1, 1'b0, 1'b0);
        end
    endfunction

    function automatic void decode_run(input logic [7:0] v, input logic [7:0] cnt);
        logic [16:0] total;
        logic        done;
        total = {1'b0, dec_produced} + {9'd0, cnt};
        if (total > {1'b0, cur_block_len})
        begin
            dec_halted   = 1'b1;
            dec_produced = '0;
            emit_word(8'd0, 8'd0, 1'b1, 1'b1);
        end
        else
        begin
            done         = (total == {1'b0, cur_block_len});
            dec_produced = done ? 16'd0 : total[15:0];
            emit_word(v, cnt, done, 1'b0);
        end
    endfunction

    // Works out the result words that one accepted item causes.
    function automatic void codec_step(input logic [7:0] b, input logic last);
        rle_word_t w;
        step_words.delete();
        if (cur_mode == MODE_ENCODE)
        begin
            if (enc_open && b == enc_value && int'(enc_count) < MAX_RUN)
                enc_count = enc_count + 8'd1;
            else
            begin
                if (enc_open)
                    flush_run();
                enc_value = b;
                enc_count = 8'd1;
                enc_open  = 1'b1;
            end
            if (last)
            begin
                flush_run();
                enc_open  = 1'b0;
                enc_count = 8'd0;
                w = step_words.pop_back();
                w.block_done = 1'b1;
                step_words.push_back(w);
            end
        end
        else if (!dec_halted)
        begin
            case (dec_phase)
                PH_VALUE:
                begin
                    dec_value = b;
                    dec_phase = PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    dec_phase = PH_PLAIN;
                    if (b != 8'd0)
                        decode_run(dec_value, b);
                end
                default:
                begin
                    dec_phase = PH_PLAIN;
                    if (b == ESC_BYTE)
                        dec_phase = PH_VALUE;
                    else
                        decode_run(b, 8'd1);
                end
            endcase
        end
    endfunction

    task automatic send_item(input logic [7:0] data, input logic last,
                             input logic typed = 1'b0, input rle_word_t want = '0);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_taken++;
        codec_step(data, last);
        if (typed)
            expected_words.push_back(want);
        else
            foreach (step_words[i])
                expected_words.push_back(step_words[i]);
    endtask

    // Registers only change once the block has drained.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_MODE)
            cur_mode = value[0];
        else
            cur_block_len = value;
        @(posedge clk);
    endtask

    task automatic run_rows(input int first, input int stop);
        stim_row_t row;
        for (int i = first; i < stop; i++)
        begin
            row = STIM_ROWS[i];
            if (row.kind == ROW_CFG)
            begin
                settle();
                cfg_write(row.cfg_index, row.value);
            end
            else
                send_item(row.value[7:0], row.last, row.typed, row.want);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            fail_count++;
            // Keep the log readable when the block is badly broken.
            if (fail_count <= PRINT_LIMIT)
                $display("%0t ns: %s expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Receiver: random back-pressure plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served   <= hold_requests;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        rle_word_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_words.size() == 0)
            begin
                fail_count++;
                if (fail_count <= PRINT_LIMIT)
                    $display("%0t ns: item with none expected, actual tdata %0h tlast %0b tuser %0b",
                             $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end
            else
            begin
                w = expected_words.pop_front();
                check_field("out_byte", int'(w.out_byte), int'(m_axis_tdata[7:0]));
                check_field("repeat_res", int'(w.repeat_cnt), int'(m_axis_tdata[15:8]));
                check_field("block_done", int'(w.block_done), int'(m_axis_tlast));
                check_field("error", int'(w.err), int'(m_axis_tuser[0]));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int          random_end;
        int          progress;
        int          seg_end;
        int          run_len;
        int          rem;
        int          max_len;
        int          new_len;
        logic        seg_mode;
        logic        full_run_done;
        logic        pressure_done;
        logic [7:0]  v;

        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = CFG_MODE;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        full_run_done = 1'b0;
        pressure_done = 1'b0;

        cur_mode      = MODE_ENCODE;
        cur_block_len = '0;
        enc_value     = '0;
        enc_count     = '0;
        enc_open      = 1'b0;
        dec_phase     = PH_PLAIN;
        dec_value     = '0;
        dec_produced  = '0;
        dec_halted    = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_rows(0, TAIL_START);

        random_end = items_taken + RANDOM_ITEMS;
        while (items_taken < random_end)
        begin
            progress = RANDOM_ITEMS - (random_end - items_taken);
            seg_end  = $urandom_range(6, 30);
            seg_mode = 1'($urandom_range(0, 1));
            settle();
            if (progress < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 9;
                recv_idle_pct = 86;
            end
            else if (progress < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 86;
                recv_idle_pct = 9;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            cfg_write(CFG_MODE, {15'd0, seg_mode});
            if ($urandom_range(0, 1) == 1)
            begin
                // Never below the bytes already produced, so decoding never halts here.
                case ($urandom_range(0, 3))
                    0: new_len = int'(dec_produced) + 1;
                    1: new_len = int'(dec_produced) + $urandom_range(1, 40);
                    2: new_len = 65535;
                    default: new_len = int'(dec_produced) + $urandom_range(1, 600);
                endcase
                if (new_len > 65535)
                    new_len = 65535;
                cfg_write(CFG_BLOCK_LENGTH, new_len[15:0]);
            end
            // Once the sender stops idling, hold the output long enough to fill the block.
            if (send_idle_pct == 0 && !pressure_done)
            begin
                pressure_done = 1'b1;
                seg_end = 40;
                hold_requests++;
            end
            seg_end = items_taken + seg_end;

            if (seg_mode == MODE_ENCODE)
            begin
                if (!full_run_done)
                begin
                    // A run past the maximum length splits in two.
                    full_run_done = 1'b1;
                    v = 8'($urandom_range(0, 255));
                    repeat ($urandom_range(MAX_RUN + 1, MAX_RUN + 5))
                        send_item(v, 1'b0);
                end
                while (items_taken < seg_end)
                begin
                    case ($urandom_range(0, 7))
                        0: v = ESC_BYTE;
                        1: v = enc_value;
                        default: v = 8'($urandom_range(0, 255));
                    endcase
                    run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 8)
                                                          : $urandom_range(1, 2);
                    for (int i = 0; i < run_len; i++)
                        send_item(v, (i == run_len - 1) && ($urandom_range(0, 3) == 0));
                end
            end
            else
            begin
                while (items_taken < seg_end)
                begin
                    rem     = int'(cur_block_len) - int'(dec_produced);
                    max_len = (rem < 255) ? rem : 255;
                    case (dec_phase)
                        PH_VALUE:
                            v = 8'($urandom_range(0, 255));
                        PH_LENGTH:
                        begin
                            case ($urandom_range(0, 5))
                                0: v = 8'd0;
                                1: v = max_len[7:0];
                                default: v = 8'($urandom_range(1, max_len));
                            endcase
                        end
                        default:
                        begin
                            if ($urandom_range(0, 2) == 0)
                                v = ESC_BYTE;
                            else
                            begin
                                v = 8'($urandom_range(0, 255));
                                if (v == ESC_BYTE)
                                    v = ~v;
                            end
                        end
                    endcase
                    send_item(v, 1'($urandom_range(0, 1)));
                end
            end
        end

        // Finish any escape sequence left open with an empty run.
        if (dec_phase != PH_PLAIN)
        begin
            settle();
            cfg_write(CFG_MODE, {15'd0, MODE_DECODE});
            while (dec_phase != PH_PLAIN)
                send_item((dec_phase == PH_VALUE) ? 8'h5A : 8'h00, 1'b0);
        end

        run_rows(TAIL_START, ROW_COUNT);

        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: escape_byte_rle_codec.f
hdl/rlc_pkg.sv
hdl/rlc_front.sv
hdl/rlc_fifo.sv
hdl/rlc_back.sv
hdl/escape_byte_rle_codec.sv
hdl/rlc_checker.sv
test/escape_byte_rle_codec_tb.sv
